[rtl/core/vft_pkg.sv]
// Shared types, constants and helper functions for the Voigt frame transform builder.
// No dependencies; imported by every module of the block.
package vft_pkg;

    localparam int VEC_BITS      = 30;
    localparam int OUT_FRAC_BITS = 29;
    localparam int NUM_COLS      = 6;

    typedef logic signed [30:0] vcomp_t;
    typedef vcomp_t [2:0] vec_t;
    typedef logic signed [31:0] cos_t;
    typedef cos_t [2:0] cvec_t;
    typedef cvec_t [2:0] cmat_t;

    typedef struct packed {
        logic  ok;
        cmat_t d;
    } frame_t;

    typedef struct packed {
        logic nz;
        vec_t v;
    } scaled_t;

    localparam logic [1:0] ENT_A [NUM_COLS] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd0};
    localparam logic [1:0] ENT_B [NUM_COLS] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

    function automatic logic [6:0] bit_len64(input logic [63:0] m);
        logic [6:0] b;
        b = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (m[i])
            begin
                b = 7'(i + 1);
            end
        end
        return b;
    endfunction

    // Block-scale a 3-vector so that its largest component has VEC_BITS bits.
    function automatic scaled_t scale3(input logic [2:0][63:0] x);
        scaled_t           o;
        logic [63:0]       mg;
        logic [63:0]       mx;
        logic [6:0]        b;
        logic [5:0]        sh;
        logic signed [63:0] t;
        mx = '0;
        for (int i = 0; i < 3; i++)
        begin
            mg = x[i][63] ? (~x[i] + 64'd1) : x[i];
            if (mg > mx)
            begin
                mx = mg;
            end
        end
        b = bit_len64(mx);
        for (int i = 0; i < 3; i++)
        begin
            if (b > 7'(VEC_BITS))
            begin
                sh = 6'(b - 7'(VEC_BITS));
                t  = $signed(x[i]) >>> sh;
            end
            else
            begin
                sh = 6'(7'(VEC_BITS) - b);
                t  = $signed(x[i]) <<< sh;
            end
            o.v[i] = t[30:0];
        end
        o.nz = |mx;
        return o;
    endfunction

endpackage

[rtl/core/vft_norm.sv]
// Unit-vector reduction of one block-scaled 3-vector: squares, iterative square root,
// iterative reciprocal, then rounded cosines. Depends on vft_pkg.
module vft_norm (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  vft_pkg::vec_t v,
    output logic          done,
    output vft_pkg::cvec_t u
);
    import vft_pkg::*;

    typedef enum logic [2:0] {N_IDLE, N_SQ, N_SUM, N_ROOT, N_DIV, N_MUL, N_RND} nstate_t;

    nstate_t     state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;

    logic [30:0] mag_reg [3];
    logic [2:0]  sgn_reg;
    logic [61:0] sq_reg [3];
    logic [63:0] x_reg, res_reg, bt_reg;
    logic [32:0] rem_reg;
    logic [33:0] quo_reg;
    logic [63:0] prod_reg [3];
    cvec_t       u_reg;

    logic [63:0] x_n, res_n, bt_n;
    logic [32:0] rem_n;
    logic [33:0] quo_n;

    always_comb
    begin
        logic [63:0] xa, ra, ba;
        logic [32:0] rm, r2;
        logic [33:0] qa;
        xa = x_reg;
        ra = res_reg;
        ba = bt_reg;
        for (int i = 0; i < 2; i++)
        begin
            if (xa >= ra + ba)
            begin
                xa = xa - (ra + ba);
                ra = (ra >> 1) + ba;
            end
            else
            begin
                ra = ra >> 1;
            end
            ba = ba >> 2;
        end
        rm = rem_reg;
        qa = quo_reg;
        for (int i = 0; i < 2; i++)
        begin
            r2 = {rm[31:0], 1'b0};
            if (r2 >= res_reg[32:0])
            begin
                rm = r2 - res_reg[32:0];
                qa = {qa[32:0], 1'b1};
            end
            else
            begin
                rm = r2;
                qa = {qa[32:0], 1'b0};
            end
        end
        x_n   = xa;
        res_n = ra;
        bt_n  = ba;
        rem_n = rm;
        quo_n = qa;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    state_next = N_SQ;
                end
            end
            N_SQ:   state_next = N_SUM;
            N_SUM:
            begin
                state_next = N_ROOT;
                cnt_next   = '0;
            end
            N_ROOT:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd15)
                begin
                    state_next = N_DIV;
                    cnt_next   = '0;
                end
            end
            N_DIV:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd16)
                begin
                    state_next = N_MUL;
                end
            end
            N_MUL:  state_next = N_RND;
            N_RND:
            begin
                state_next = N_IDLE;
                done_next  = 1'b1;
            end
            default: state_next = N_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [63:0] q;
        case (state_reg)
            N_IDLE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sgn_reg[i] <= v[i][30];
                    mag_reg[i] <= v[i][30] ? 31'(~v[i] + 31'sd1) : 31'(v[i]);
                end
            end
            N_SQ:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sq_reg[i] <= 62'(mag_reg[i]) * 62'(mag_reg[i]);
                end
            end
            N_SUM:
            begin
                x_reg   <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
                res_reg <= '0;
                bt_reg  <= 64'd1 << 62;
                rem_reg <= 33'd1 << 27;
                quo_reg <= '0;
            end
            N_ROOT:
            begin
                x_reg   <= x_n;
                res_reg <= res_n;
                bt_reg  <= bt_n;
            end
            N_DIV:
            begin
                rem_reg <= rem_n;
                quo_reg <= quo_n;
            end
            N_MUL:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    prod_reg[i] <= 64'(mag_reg[i]) * 64'(quo_reg[32:0]);
                end
            end
            N_RND:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    q = (prod_reg[i] + (64'd1 << (60 - OUT_FRAC_BITS))) >> (61 - OUT_FRAC_BITS);
                    u_reg[i] <= sgn_reg[i] ? -$signed(q[31:0]) : $signed(q[31:0]);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done = done_reg;
    assign u    = u_reg;

endmodule

[rtl/core/vft_front.sv]
// Front end: accepts a beat, block-scales r and s, forms n and c by cross products,
// flags zero-length frames and runs three vft_norm units. Depends on vft_pkg, vft_norm.
module vft_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic signed [31:0] r_tangent_x,
    input  logic signed [31:0] r_tangent_y,
    input  logic signed [31:0] r_tangent_z,
    input  logic signed [31:0] s_tangent_x,
    input  logic signed [31:0] s_tangent_y,
    input  logic signed [31:0] s_tangent_z,
    output logic              push,
    output vft_pkg::frame_t   push_data,
    input  logic              full
);
    import vft_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SCALE_RS, S_MUL_N, S_SUB_N, S_SCALE_N,
        S_MUL_C, S_SUB_C, S_SCALE_C, S_NORM, S_WAIT, S_PUSH
    } fstate_t;

    fstate_t            state_reg, state_next;
    logic               ok_reg, ok_next;

    logic [2:0][63:0]   rin_reg, sin_reg;
    vec_t               r_reg, s_reg, n_reg, c_reg;
    logic signed [61:0] prod_reg [6];
    logic [2:0][63:0]   diff_reg;

    scaled_t            sc_r, sc_s, sc_d;
    vec_t               ma, mb;
    logic               norm_start;
    logic [2:0]         norm_done;
    cvec_t              u_r, u_c, u_n;

    assign sc_r = scale3(rin_reg);
    assign sc_s = scale3(sin_reg);
    assign sc_d = scale3(diff_reg);
    assign ma   = (state_reg == S_MUL_C) ? n_reg : r_reg;
    assign mb   = (state_reg == S_MUL_C) ? r_reg : s_reg;
    assign norm_start = (state_reg == S_NORM);

    vft_norm u_norm_r (.clk(clk), .rst_n(rst_n), .start(norm_start), .v(r_reg),
                       .done(norm_done[0]), .u(u_r));
    vft_norm u_norm_c (.clk(clk), .rst_n(rst_n), .start(norm_start), .v(c_reg),
                       .done(norm_done[1]), .u(u_c));
    vft_norm u_norm_n (.clk(clk), .rst_n(rst_n), .start(norm_start), .v(n_reg),
                       .done(norm_done[2]), .u(u_n));

    always_comb
    begin
        state_next = state_reg;
        ok_next    = ok_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCALE_RS;
                end
            end
            S_SCALE_RS:
            begin
                ok_next    = sc_r.nz & sc_s.nz;
                state_next = (sc_r.nz & sc_s.nz) ? S_MUL_N : S_PUSH;
            end
            S_MUL_N:   state_next = S_SUB_N;
            S_SUB_N:   state_next = S_SCALE_N;
            S_SCALE_N:
            begin
                ok_next    = sc_d.nz;
                state_next = sc_d.nz ? S_MUL_C : S_PUSH;
            end
            S_MUL_C:   state_next = S_SUB_C;
            S_SUB_C:   state_next = S_SCALE_C;
            S_SCALE_C:
            begin
                ok_next    = sc_d.nz;
                state_next = sc_d.nz ? S_NORM : S_PUSH;
            end
            S_NORM:    state_next = S_WAIT;
            S_WAIT:
            begin
                if (&norm_done)
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (!full)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ok_reg    <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                rin_reg <= {64'(r_tangent_z), 64'(r_tangent_y), 64'(r_tangent_x)};
                sin_reg <= {64'(s_tangent_z), 64'(s_tangent_y), 64'(s_tangent_x)};
            end
            S_SCALE_RS:
            begin
                r_reg <= sc_r.v;
                s_reg <= sc_s.v;
            end
            S_MUL_N, S_MUL_C:
            begin
                prod_reg[0] <= ma[1] * mb[2];
                prod_reg[1] <= ma[2] * mb[1];
                prod_reg[2] <= ma[2] * mb[0];
                prod_reg[3] <= ma[0] * mb[2];
                prod_reg[4] <= ma[0] * mb[1];
                prod_reg[5] <= ma[1] * mb[0];
            end
            S_SUB_N, S_SUB_C:
            begin
                diff_reg[0] <= 64'(prod_reg[0]) - 64'(prod_reg[1]);
                diff_reg[1] <= 64'(prod_reg[2]) - 64'(prod_reg[3]);
                diff_reg[2] <= 64'(prod_reg[4]) - 64'(prod_reg[5]);
            end
            S_SCALE_N: n_reg <= sc_d.v;
            S_SCALE_C: c_reg <= sc_d.v;
            default:
            begin
            end
        endcase
    end

    assign busy        = (state_reg != S_IDLE);
    assign push        = (state_reg == S_PUSH) && !full;
    assign push_data.ok = ok_reg;
    assign push_data.d  = ok_reg ? {u_n, u_c, u_r} : '0;

endmodule

[rtl/core/vft_queue.sv]
// Two-entry queue of cosine frames between front and back.
// Depends on vft_pkg.
module vft_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  vft_pkg::frame_t push_data,
    output logic            full,
    input  logic            pop,
    output vft_pkg::frame_t pop_data,
    output logic            empty
);
    import vft_pkg::*;

    frame_t     mem [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= push_data;
        end
    end

    assign pop_data = mem[rp_reg];
    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);

endmodule

[rtl/core/vft_back.sv]
// Back end: walks the twelve Voigt columns of a cosine frame, one per cycle,
// through a multiply stage and a round/saturate stage. Depends on vft_pkg.
module vft_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               empty,
    input  vft_pkg::frame_t    frame,
    output logic               pop,
    output logic               strobe,
    output logic               which_matrix,
    output logic [2:0]         column_index,
    output logic signed [31:0] entry_row0,
    output logic signed [31:0] entry_row1,
    output logic signed [31:0] entry_row2,
    output logic signed [31:0] entry_row3,
    output logic signed [31:0] entry_row4,
    output logic signed [31:0] entry_row5,
    output logic               degenerate,
    output logic               last_of_run
);
    import vft_pkg::*;

    function automatic logic signed [31:0] round_entry(input logic signed [63:0] p);
        logic [63:0] mg;
        logic [63:0] a;
        mg = p[63] ? (~p + 64'd1) : p;
        a  = (mg + (64'd1 << (OUT_FRAC_BITS - 1))) >> OUT_FRAC_BITS;
        if (!p[63])
        begin
            return (a > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(a[31:0]);
        end
        return (a > 64'h8000_0000) ? 32'sh8000_0000 : -$signed(a[31:0]);
    endfunction

    frame_t             cur_reg;
    logic               act_reg;
    logic               m_reg;
    logic [2:0]         k_reg;
    logic               at_last;

    logic               s1_valid_reg, s1_m_reg, s1_ok_reg;
    logic [2:0]         s1_k_reg;
    logic signed [63:0] t1_reg [NUM_COLS];
    logic signed [63:0] t2_reg [NUM_COLS];

    logic               o_valid_reg, o_m_reg, o_ok_reg, o_last_reg;
    logic [2:0]         o_k_reg;
    logic signed [31:0] o_e_reg [NUM_COLS];

    cmat_t              am;
    logic [1:0]         pi, qi;

    assign at_last = m_reg && (k_reg == 3'(NUM_COLS - 1));
    assign pop     = !empty && (!act_reg || at_last);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                am[i][j] = m_reg ? cur_reg.d[j][i] : cur_reg.d[i][j];
            end
        end
        case (k_reg)
            3'd3:    begin pi = 2'd0; qi = 2'd1; end
            3'd4:    begin pi = 2'd1; qi = 2'd2; end
            3'd5:    begin pi = 2'd0; qi = 2'd2; end
            default: begin pi = k_reg[1:0]; qi = k_reg[1:0]; end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg      <= 1'b0;
            m_reg        <= 1'b0;
            k_reg        <= '0;
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= act_reg;
            o_valid_reg  <= s1_valid_reg;
            if (pop)
            begin
                act_reg <= 1'b1;
                m_reg   <= 1'b0;
                k_reg   <= '0;
            end
            else if (act_reg)
            begin
                if (at_last)
                begin
                    act_reg <= 1'b0;
                end
                else if (k_reg == 3'(NUM_COLS - 1))
                begin
                    m_reg <= 1'b1;
                    k_reg <= '0;
                end
                else
                begin
                    k_reg <= k_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= frame;
        end
        s1_m_reg  <= m_reg;
        s1_k_reg  <= k_reg;
        s1_ok_reg <= cur_reg.ok;
        for (int j = 0; j < NUM_COLS; j++)
        begin
            t1_reg[j] <= am[pi][ENT_A[j]] * am[qi][ENT_B[j]];
            t2_reg[j] <= (k_reg >= 3'd3) ? am[qi][ENT_A[j]] * am[pi][ENT_B[j]] : 64'sd0;
        end
        o_m_reg    <= s1_m_reg;
        o_k_reg    <= s1_k_reg;
        o_ok_reg   <= s1_ok_reg;
        o_last_reg <= s1_m_reg && (s1_k_reg == 3'(NUM_COLS - 1));
        for (int j = 0; j < NUM_COLS; j++)
        begin
            o_e_reg[j] <= s1_ok_reg ? round_entry(t1_reg[j] + t2_reg[j]) : 32'sd0;
        end
    end

    assign strobe       = o_valid_reg;
    assign which_matrix = o_m_reg;
    assign column_index = o_k_reg;
    assign entry_row0   = o_e_reg[0];
    assign entry_row1   = o_e_reg[1];
    assign entry_row2   = o_e_reg[2];
    assign entry_row3   = o_e_reg[3];
    assign entry_row4   = o_e_reg[4];
    assign entry_row5   = o_e_reg[5];
    assign degenerate   = !o_ok_reg;
    assign last_of_run  = o_last_reg;

endmodule

[rtl/core/voigt_frame_transform_builder_unit.sv]
// Top level of the Voigt frame transform builder.
// Depends on vft_pkg, vft_front, vft_norm, vft_queue and vft_back.
//
// Usage:
//   Input: drive the six tangent components and raise start; the beat is taken
//   at a clock edge where start is high and busy is low.
//   Output: twelve results per beat, g columns 0..5 then gi columns 0..5, each
//   on the result ports for one cycle with strobe high; last_of_run marks the
//   twelfth. The receiver cannot stall; results go out one per cycle.
//   Path: from the accepting edge to the first strobe, a good frame passes
//   through scaling and cross products, then in each of three vector units a
//   load, square, sum, iterative square root, iterative reciprocal, multiply,
//   round and done step, then the push, the load into the back end and its two
//   output stages; a zero length frame skips the vector units.
//   Pacing: on a good frame the front end's square root and reciprocal
//   sequence sets the beat rate; zero length frames are paced by the back end's
//   twelve columns each. A two-frame queue lets the front end start the next
//   beat while the back end still emits columns.
//   Reset: clears all control state; queue empty, no strobes.
module voigt_frame_transform_builder_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] r_tangent_x,
    input  logic signed [31:0] r_tangent_y,
    input  logic signed [31:0] r_tangent_z,
    input  logic signed [31:0] s_tangent_x,
    input  logic signed [31:0] s_tangent_y,
    input  logic signed [31:0] s_tangent_z,
    output logic               strobe,
    output logic               which_matrix,
    output logic [2:0]         column_index,
    output logic signed [31:0] entry_row0,
    output logic signed [31:0] entry_row1,
    output logic signed [31:0] entry_row2,
    output logic signed [31:0] entry_row3,
    output logic signed [31:0] entry_row4,
    output logic signed [31:0] entry_row5,
    output logic               degenerate,
    output logic               last_of_run
);
    import vft_pkg::*;

    logic   q_push, q_full, q_pop, q_empty;
    frame_t q_in, q_out;

    vft_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .r_tangent_x(r_tangent_x), .r_tangent_y(r_tangent_y), .r_tangent_z(r_tangent_z),
        .s_tangent_x(s_tangent_x), .s_tangent_y(s_tangent_y), .s_tangent_z(s_tangent_z),
        .push(q_push), .push_data(q_in), .full(q_full)
    );

    vft_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .pop_data(q_out), .empty(q_empty)
    );

    vft_back u_back (
        .clk(clk), .rst_n(rst_n), .empty(q_empty), .frame(q_out), .pop(q_pop),
        .strobe(strobe), .which_matrix(which_matrix), .column_index(column_index),
        .entry_row0(entry_row0), .entry_row1(entry_row1), .entry_row2(entry_row2),
        .entry_row3(entry_row3), .entry_row4(entry_row4), .entry_row5(entry_row5),
        .degenerate(degenerate), .last_of_run(last_of_run)
    );

endmodule
